// ----- rtl/dtd_pkg.sv -----
// dtd_pkg: shared types and constants for the double to decimal digits block
// used by dtd_out_if, the controller, datapath, top level and checker; no dependencies
package dtd_pkg;

    localparam int MaxDigitsDef = 17;
    // wide enough for 2^1074 and for ten times any intermediate value
    localparam int WideW = 1088;
    localparam int ExpW = 10;

    localparam logic [51:0] FracMask = 52'hF_FFFF_FFFF_FFFF;
    localparam logic [10:0] BiasPlusMant = 11'd1075;
    localparam logic [10:0] SubnShift = 11'd1074;
    localparam logic [3:0] DigitMax = 4'd9;
    localparam logic [3:0] DigitHalf = 4'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_UP,
        S_DOWN,
        S_SUB,
        S_NEXT,
        S_RINIT,
        S_ROUND,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_UP,
        OP_DOWN,
        OP_SUB,
        OP_NEXT,
        OP_RINIT,
        OP_RND,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic zero;
        logic up_stop;
        logic down_stop;
        logic sub_stop;
        logic last_digit;
        logic rnd_done;
        logic emit_last;
    } t_status;

    function automatic logic [WideW-1:0] mul10(input logic [WideW-1:0] x);
        mul10 = (x << 3) + (x << 1);
    endfunction

endpackage

// ----- rtl/dtd_if.sv -----
// dtd_in_if / dtd_out_if: valid-ready channels for input items and digit items
// depends on dtd_pkg
interface dtd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;
    logic [4:0]  digit_count;

    modport source (output valid, output value_bits, output digit_count, input ready);
    modport sink (input valid, input value_bits, input digit_count, output ready);
endinterface

interface dtd_out_if;
    import dtd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [3:0]             digit;
    logic signed [ExpW-1:0] decimal_exponent;
    logic                   is_last;

    modport source (output valid, output digit, output decimal_exponent, output is_last,
                    input ready);
    modport sink (input valid, input digit, input decimal_exponent, input is_last,
                  output ready);
endinterface

// ----- rtl/double_to_decimal_digits_top.sv -----
// double_to_decimal_digits_top: exact decimal digits of a binary64 value
// depends on dtd_pkg, dtd_if, dtd_ctrl and dtd_datapath
//
// usage:
//   i_in carries value_bits (raw binary64, sign ignored) and digit_count,
//   clamped to 1..MAX_DIGITS. o_out returns one item per digit, most
//   significant first, each with the decimal exponent of the first digit
//   and is_last on the final one. A zero value gives the single digit 0
//   with exponent 0.
//   one conversion at a time: i_in.ready is high only while idle, and the
//   next item can be taken the cycle after the last digit is accepted.
//   steps: a load and a zero check, then scaling by one power of ten at a
//   time, up or down, set by the wide mul-by-10 and compare, then per
//   digit repeated subtraction of the denominator plus a shift, for
//   count+1 digits, then rounding with carry propagation, then the digits
//   out in order; a zero value goes from the check straight to the
//   output.
//   the receiver may stall o_out at any point; the current digit holds.
//   reset returns the controller to idle, dropping any conversion in flight.
module double_to_decimal_digits_top #(
    parameter int MAX_DIGITS = dtd_pkg::MaxDigitsDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtd_in_if.sink    i_in,
    dtd_out_if.source o_out
);
    import dtd_pkg::*;

    t_op     op;
    t_status status;
    logic    in_ready, out_valid;

    dtd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_op        (op)
    );

    dtd_datapath #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
        .i_clk         (i_clk),
        .i_op          (op),
        .i_value_bits  (i_in.value_bits),
        .i_digit_count (i_in.digit_count),
        .o_status      (status),
        .o_digit       (o_out.digit),
        .o_exp         (o_out.decimal_exponent),
        .o_last        (o_out.is_last)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

// ----- rtl/dtd_ctrl.sv -----
// dtd_ctrl: sequencing state machine for the conversion
// depends on dtd_pkg; drives ops into dtd_datapath and reads its status
module dtd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  dtd_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output dtd_pkg::t_op     o_op
);
    import dtd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CHECK;
            S_CHECK: n_state = i_status.zero ? S_EMIT : S_UP;
            S_UP:    if (i_status.up_stop) n_state = S_DOWN;
            S_DOWN:  if (i_status.down_stop) n_state = S_SUB;
            S_SUB:   if (i_status.sub_stop) n_state = S_NEXT;
            S_NEXT:  n_state = i_status.last_digit ? S_RINIT : S_SUB;
            S_RINIT: n_state = S_ROUND;
            S_ROUND: if (i_status.rnd_done) n_state = S_EMIT;
            S_EMIT:  if (i_out_ready && i_status.emit_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_op        = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_op = OP_LOAD;
            end
            S_CHECK: o_op = OP_NONE;
            S_UP:    o_op = OP_UP;
            S_DOWN:  o_op = OP_DOWN;
            S_SUB:   o_op = OP_SUB;
            S_NEXT:  o_op = OP_NEXT;
            S_RINIT: o_op = OP_RINIT;
            S_ROUND: o_op = OP_RND;
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) o_op = OP_EMIT;
            end
            default: o_op = OP_NONE;
        endcase
    end

endmodule

// ----- rtl/dtd_datapath.sv -----
// dtd_datapath: wide numerator/denominator registers, digit buffer and exponent
// depends on dtd_pkg; commanded by dtd_ctrl through t_op
module dtd_datapath #(
    parameter int MAX_DIGITS = dtd_pkg::MaxDigitsDef
) (
    input  logic                           i_clk,
    input  dtd_pkg::t_op                   i_op,
    input  logic [63:0]                    i_value_bits,
    input  logic [4:0]                     i_digit_count,
    output dtd_pkg::t_status               o_status,
    output logic [3:0]                     o_digit,
    output logic signed [dtd_pkg::ExpW-1:0] o_exp,
    output logic                           o_last
);
    import dtd_pkg::*;

    localparam int NW = $clog2(MAX_DIGITS + 1);
    localparam logic [NW-1:0] MaxN = NW'(MAX_DIGITS);

    logic [WideW-1:0]       r_num, r_den;
    logic signed [ExpW-1:0] r_exp;
    logic [3:0]             r_buf [0:MAX_DIGITS];
    logic [3:0]             r_d;
    logic [NW-1:0]          r_idx, r_ndig, r_ri, r_eidx;
    logic                   r_carry, r_zero;

    // load decode
    logic [51:0]      frac;
    logic [10:0]      be;
    logic [52:0]      mant;
    logic [10:0]      dshift;
    logic [WideW-1:0] load_num, load_den;
    logic [NW-1:0]    ndig_clamp;

    // arithmetic
    logic [WideW-1:0] den10, num10;
    logic [WideW:0]   diff;
    logic             borrow;
    logic             up_stop, down_stop, sub_stop;
    logic [3:0]       g_dig, p_dig, cur_dig;
    logic             sticky, rnd_inc;

    always_comb begin
        frac = i_value_bits[51:0] & FracMask;
        be   = i_value_bits[62:52];
        mant = (be == 11'd0) ? {1'b0, frac} : {1'b1, frac};
        dshift = (be == 11'd0) ? SubnShift
               : ((be < BiasPlusMant) ? (BiasPlusMant - be) : 11'd0);
        if (be >= BiasPlusMant) begin
            load_num = WideW'(mant) << (be - BiasPlusMant);
        end else begin
            load_num = WideW'(mant);
        end
        load_den = WideW'(1) << dshift;
        if (i_digit_count == 5'd0) begin
            ndig_clamp = NW'(1);
        end else if (32'(i_digit_count) > 32'(MAX_DIGITS)) begin
            ndig_clamp = MaxN;
        end else begin
            ndig_clamp = NW'(i_digit_count);
        end
    end

    always_comb begin
        den10     = mul10(r_den);
        num10     = mul10(r_num);
        up_stop   = r_num < den10;
        diff      = {1'b0, r_num} - {1'b0, r_den};
        borrow    = diff[WideW];
        down_stop = !borrow;
        sub_stop  = borrow || (r_d == DigitMax);
        g_dig     = r_buf[r_ndig];
        p_dig     = r_buf[r_ndig - NW'(1)];
        sticky    = |r_num;
        rnd_inc   = (g_dig > DigitHalf) || ((g_dig == DigitHalf) && (sticky || p_dig[0]));
        cur_dig   = r_buf[r_ri];
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_num  <= load_num;
                r_den  <= load_den;
                r_exp  <= '0;
                r_d    <= '0;
                r_idx  <= '0;
                r_eidx <= '0;
                r_zero <= (mant == 53'd0);
                if (mant == 53'd0) begin
                    r_ndig   <= NW'(1);
                    r_buf[0] <= '0;
                end else begin
                    r_ndig <= ndig_clamp;
                end
            end
            OP_UP: begin
                if (!up_stop) begin
                    r_den <= den10;
                    r_exp <= r_exp + ExpW'(1);
                end
            end
            OP_DOWN: begin
                if (!down_stop) begin
                    r_num <= num10;
                    r_exp <= r_exp - ExpW'(1);
                end
            end
            OP_SUB: begin
                if (!sub_stop) begin
                    r_num <= diff[WideW-1:0];
                    r_d   <= r_d + 4'd1;
                end
            end
            OP_NEXT: begin
                r_buf[r_idx] <= r_d;
                r_d          <= '0;
                r_num        <= num10;
                r_idx        <= r_idx + NW'(1);
            end
            OP_RINIT: begin
                r_carry <= rnd_inc;
                r_ri    <= r_ndig - NW'(1);
            end
            OP_RND: begin
                if (r_carry) begin
                    if (cur_dig != DigitMax) begin
                        r_buf[r_ri] <= cur_dig + 4'd1;
                        r_carry     <= 1'b0;
                    end else if (r_ri == '0) begin
                        // carry out of all nines
                        r_buf[r_ri] <= 4'd1;
                        r_exp       <= r_exp + ExpW'(1);
                        r_carry     <= 1'b0;
                    end else begin
                        r_buf[r_ri] <= '0;
                        r_ri        <= r_ri - NW'(1);
                    end
                end
            end
            OP_EMIT: r_eidx <= r_eidx + NW'(1);
            default: ;
        endcase
    end

    always_comb begin
        o_status.zero       = r_zero;
        o_status.up_stop    = up_stop;
        o_status.down_stop  = down_stop;
        o_status.sub_stop   = sub_stop;
        o_status.last_digit = (r_idx == r_ndig);
        o_status.rnd_done   = !r_carry || (r_ri == '0);
        o_status.emit_last  = (r_eidx == r_ndig - NW'(1));
        o_digit = r_buf[r_eidx];
        o_exp   = r_exp;
        o_last  = (r_eidx == r_ndig - NW'(1));
    end

endmodule

// ----- rtl/dtd_checker.sv -----
// dtd_checker: port-level assertions for double_to_decimal_digits_top
// depends on dtd_pkg; attached by the bind below
module dtd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [3:0]                      i_digit,
    input logic signed [dtd_pkg::ExpW-1:0] i_exp,
    input logic                            i_last
);
    import dtd_pkg::*;

    // one conversion at a time
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready while a digit is offered");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("digit offered right after an item was taken");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_last) |=> i_in_ready)
        else $error("not idle after last digit");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_digit <= DigitMax))
        else $error("digit out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_digit) && $stable(i_exp)
                                          && $stable(i_last)))
        else $error("stalled digit changed");

endmodule

bind double_to_decimal_digits_top dtd_checker u_dtd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_digit     (o_out.digit),
    .i_exp       (o_out.decimal_exponent),
    .i_last      (o_out.is_last)
);
